[hdl/smpq_pkg.sv]
package smpq_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;
  localparam int HELD_W       = 5;

  // item kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] value;
  } smpq_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic              valid;
    logic              keep;
    logic [DATA_W-1:0] data;
  } smpq_link_t;

endpackage

[hdl/smpq_cell.sv]
module smpq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  smpq_pkg::smpq_cmd_t           cmd,
  input  smpq_pkg::smpq_link_t          upper,
  input  smpq_pkg::smpq_link_t          lower,
  output smpq_pkg::smpq_link_t          self,
  output logic [smpq_pkg::DATA_W-1:0]   data_next
);
  import smpq_pkg::*;

  logic [DATA_W-1:0] data;
  logic              valid;
  logic              valid_next;
  logic              less;
  logic              keep;

  // a held value that is not below the new one stays; equals stay ahead
  assign less = $signed(data) < $signed(cmd.value);
  assign keep = valid & ~less;

  assign self.valid = valid;
  assign self.keep  = keep;
  assign self.data  = data;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (cmd.ins) begin
      if (!keep) begin
        if (upper.keep) begin
          // insertion point: take the new value
          data_next  = cmd.value;
          valid_next = 1'b1;
        end else begin
          // shift down one place
          data_next  = upper.data;
          valid_next = upper.valid;
        end
      end
    end else if (cmd.rem) begin
      // advance toward the head
      data_next  = lower.data;
      valid_next = lower.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[hdl/sorted_max_priority_queue_core.sv]
// Bounded max-first priority queue of signed 32-bit values.
//
// Item channel (item_valid/item_stall, fields kind and value): kind
// KIND_INSERT places value after any equal values already held, kind
// KIND_REMOVE takes out the largest value. Every accepted transaction
// yields exactly one result transaction on the result channel
// (result_valid/result_stall) carrying largest, smallest, held, dropped and
// empty_remove as they stand after that item.
//
// result_valid rises in the cycle after acceptance. Throughput is one
// item per cycle unless the receiver stalls: the values live in a row of
// CAPACITY cells, each comparing its entry against the broadcast value and
// holding, loading it or taking a neighbor's entry, all in the same cycle.
//
// When the receiver stalls, the result register holds its transaction and
// item_stall rises, so at most one result waits. Reset empties the queue
// (cell valid bits and the count clear at once; no clearing pass) and drops
// any pending result. An insert into a full queue is flagged by dropped,
// a remove from an empty queue by empty_remove; neither changes the state.
module sorted_max_priority_queue_core #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          kind,
  input  logic [smpq_pkg::DATA_W-1:0]   value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [smpq_pkg::DATA_W-1:0]   largest,
  output logic [smpq_pkg::DATA_W-1:0]   smallest,
  output logic [smpq_pkg::HELD_W-1:0]   held,
  output logic                          dropped,
  output logic                          empty_remove
);
  import smpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  smpq_cmd_t         cmd;
  smpq_link_t        links [CAPACITY];
  smpq_link_t        uppers [CAPACITY];
  smpq_link_t        lowers [CAPACITY];
  logic [DATA_W-1:0] cell_next [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W+HELD_W-1:0] count_wide;
  logic [DATA_W-1:0]       tail;
  logic [DATA_W-1:0]       tail_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    do_ins;
  logic                    do_rem;

  // hold new items while a finished result waits
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);
  assign do_ins = accept & (kind == KIND_INSERT) & ~full;
  assign do_rem = accept & (kind == KIND_REMOVE) & ~empty;

  assign cmd.ins   = do_ins;
  assign cmd.rem   = do_rem;
  assign cmd.value = value;

  // row of cells, head (largest) at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign uppers[i] = '{valid: 1'b1, keep: 1'b1, data: '0};
    end else begin : g_mid
      assign uppers[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign lowers[i] = '{valid: 1'b0, keep: 1'b0, data: '0};
    end else begin : g_body
      assign lowers[i] = links[i+1];
    end

    smpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .upper     (uppers[i]),
      .lower     (lowers[i]),
      .self      (links[i]),
      .data_next (cell_next[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // count and tail (smallest) tracking
  always_comb begin
    count_next = count;
    tail_next  = tail;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
      if (empty || ($signed(value) < $signed(tail))) begin
        tail_next = value;
      end
    end else if (do_rem) begin
      count_next = count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        tail_next = '0;
      end
    end
  end

  assign count_wide = {{HELD_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tail <= tail_next;
    if (accept) begin
      largest      <= (count_next == '0) ? '0 : cell_next[0];
      smallest     <= (count_next == '0) ? '0 : tail_next;
      held         <= count_wide[HELD_W-1:0];
      dropped      <= (kind == KIND_INSERT) & full;
      empty_remove <= (kind == KIND_REMOVE) & empty;
    end
  end

  // cell valid bits form a prefix whose length is the count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell valid bits disagree with count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec & (valid_vec + CAPACITY'(1))) == '0))
    else $error("cell valid bits not contiguous from head");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(dropped && empty_remove))
    else $error("both flags set on one result");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (held != '0)) |-> ($signed(largest) >= $signed(smallest)))
    else $error("largest below smallest");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

endmodule

[test/tb_sorted_max_priority_queue_core.sv]
module tb_sorted_max_priority_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import smpq_pkg::*;

  localparam int DEPTH      = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;

  // What one result transaction should carry after an item.
  typedef struct {
    logic [DATA_W-1:0] largest;
    logic [DATA_W-1:0] smallest;
    logic [HELD_W-1:0] held;
    logic              dropped;
    logic              empty_remove;
  } queue_status_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic              kind         = KIND_INSERT;
  logic [DATA_W-1:0] value        = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [DATA_W-1:0] largest;
  logic [DATA_W-1:0] smallest;
  logic [HELD_W-1:0] held;
  logic              dropped;
  logic              empty_remove;

  // Knobs for the two idling generators.
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;

  // Shadow copy of the queue, kept in descending order.
  logic signed [DATA_W-1:0] shadow_vals [DEPTH];
  int                       shadow_count = 0;

  // Statuses predicted for accepted items, oldest first.
  queue_status_t pending_status [$];

  int error_count    = 0;
  int items_taken    = 0;
  int results_seen   = 0;
  int full_hits      = 0;
  int refused_hits   = 0;
  int empty_rm_hits  = 0;
  int idle_cycles    = 0;
  int stall_left     = 0;

  sorted_max_priority_queue_core #(
    .CAPACITY(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .largest      (largest),
    .smallest     (smallest),
    .held         (held),
    .dropped      (dropped),
    .empty_remove (empty_remove)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one item to the shadow queue and return the status it leaves behind.
  // Equal values go behind the ones already held, so ties leave in arrival order.
  task automatic track_queue(input logic k, input logic signed [DATA_W-1:0] v,
                             output queue_status_t st);
    int pos;
    st.dropped      = 1'b0;
    st.empty_remove = 1'b0;
    if (k == KIND_INSERT) begin
      if (shadow_count >= DEPTH) begin
        st.dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < shadow_count && !(shadow_vals[pos] < v)) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = v;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        st.empty_remove = 1'b1;
      end else begin
        for (int i = 1; i < shadow_count; i++) shadow_vals[i-1] = shadow_vals[i];
        shadow_count--;
      end
    end
    if (shadow_count == 0) begin
      st.largest  = '0;
      st.smallest = '0;
    end else begin
      st.largest  = shadow_vals[0];
      st.smallest = shadow_vals[shadow_count-1];
    end
    st.held = HELD_W'(shadow_count);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Predict on every accepted item transaction, then check every accepted
  // result transaction against the oldest prediction. Predicting first keeps
  // the order right whatever the latency.
  always @(posedge clk) begin
    queue_status_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        track_queue(kind, value, want);
        pending_status.push_back(want);
        items_taken++;
        if (want.held == DEPTH) full_hits++;
        if (want.dropped) refused_hits++;
        if (want.empty_remove) empty_rm_hits++;
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          report_mismatch("result transaction with no item pending");
        end else begin
          want = pending_status.pop_front();
          check_field("largest", largest, want.largest);
          check_field("smallest", smallest, want.smallest);
          check_field("held", DATA_W'(held), DATA_W'(want.held));
          check_field("dropped", DATA_W'(dropped), DATA_W'(want.dropped));
          check_field("empty_remove", DATA_W'(empty_remove), DATA_W'(want.empty_remove));
        end
      end
    end
  end

  // Receiver side: stall in random bursts while enabled.
  always @(posedge clk) begin
    logic next_stall;
    next_stall = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      next_stall = 1'b1;
    end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      next_stall = 1'b1;
    end
    result_stall <= next_stall;
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one item: maybe idle first, then hold the payload until accepted.
  task automatic send_item(input logic k, input logic [DATA_W-1:0] v);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    value      <= v;
    do @(posedge clk); while (item_stall);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // Some small values to force ties, some extremes; mostly full-width noise.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return DATA_W'($signed($urandom_range(0, 8)) - 4);
      2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3:       return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Empty remove, both extremes, zero and a tie; then take the largest out.
  task automatic test_extremes_and_ties();
    send_item(KIND_REMOVE, 32'h0000_0000);
    send_item(KIND_INSERT, 32'h7fff_ffff);
    send_item(KIND_INSERT, 32'h8000_0000);
    send_item(KIND_INSERT, 32'h0000_0000);
    send_item(KIND_INSERT, 32'hffff_ffff);
    send_item(KIND_INSERT, 32'h0000_0000);
    send_item(KIND_REMOVE, 32'hdead_beef);
  endtask

  // Top the queue up to capacity with ties at both ends, then push past it.
  task automatic test_fill_and_overflow();
    logic [DATA_W-1:0] fill_vals [12];
    fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff,
                  32'h8000_0001, 32'h7fff_fffe, 32'h0000_0000, 32'h5555_5555,
                  32'haaaa_aaaa, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff};
    foreach (fill_vals[i]) send_item(KIND_INSERT, fill_vals[i]);
    send_item(KIND_INSERT, 32'h1234_5678);
    send_item(KIND_INSERT, 32'h7fff_ffff);
    send_item(KIND_REMOVE, 32'h0000_0000);
  endtask

  // Hold the sender until the block has answered everything sent so far.
  task automatic test_sender_pause();
    wait_drained();
  endtask

  // Random runs biased to fill or to drain, so full and empty are both
  // reached many times; mixed runs supply the noise in between.
  task automatic test_random_sequences(input int count);
    int sent;
    int run_len;
    int ins_pct;
    sent = 0;
    while (sent < count) begin
      run_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (int i = 0; i < run_len && sent < count; i++) begin
        if ($urandom_range(1, 100) <= ins_pct) send_item(KIND_INSERT, pick_value());
        else send_item(KIND_REMOVE, $urandom);
        sent++;
      end
    end
  endtask

  // Closing stretch at full rate with no idling on either side.
  task automatic test_back_to_back(input int count);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    wait (stall_left == 0);
    test_random_sequences(count);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes_and_ties();
    test_fill_and_overflow();
    test_sender_pause();
    test_random_sequences(500);
    test_sender_pause();
    test_back_to_back(100);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d results, directed extremes and ties first",
             items_taken, results_seen);
    $display("queue full %0d times, %0d inserts refused, %0d removes on empty",
             full_hits, refused_hits, empty_rm_hits);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
